>>> src/lpgc_pkg.sv
// shared types and constants for the linear probing group-count table
`timescale 1ns / 1ps
`default_nettype none

package lpgc_pkg;

  // field widths
  localparam int KeyW      = 32;
  localparam int CntW      = 32;
  localparam int OpW       = 2;
  localparam int StatusW   = 2;
  localparam int CfgSizeW  = 11;
  localparam int CfgDataW  = 32;
  localparam int CfgIdxW   = 1;
  localparam int BitCntW   = $clog2(KeyW);

  // operation codes
  localparam logic [OpW-1:0] OP_INSERT = 2'd0;
  localparam logic [OpW-1:0] OP_QUERY  = 2'd1;
  localparam logic [OpW-1:0] OP_CLEAR  = 2'd2;

  // result status codes
  localparam logic [StatusW-1:0] ST_OK   = 2'd0;
  localparam logic [StatusW-1:0] ST_MISS = 2'd1;
  localparam logic [StatusW-1:0] ST_FULL = 2'd2;
  localparam logic [StatusW-1:0] ST_KEY0 = 2'd3;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CFG_TABLE_SIZE = 1'b0;
  localparam logic [CfgIdxW-1:0] CFG_HASH_MULT  = 1'b1;

  // configuration reset values
  localparam logic [CfgSizeW-1:0] CFG_SIZE_RESET = 11'd1024;
  localparam logic [KeyW-1:0]     CFG_MULT_RESET = 32'd1;

endpackage

`default_nettype wire

>>> src/linear_probe_group_count.sv
// top level of the linear probing group-count hash table
`timescale 1ns / 1ps
`default_nettype none

// Group-count hash table with open addressing and linear probing over one
// single-port slot memory of MAX_SLOTS entries (key and count side by side).
// Requests are taken one at a time. An insert or query forms the key times
// multiplier product, takes the bit-serial remainder by the table size that
// gives the home slot, then for each probed slot reads the memory and then
// compares and writes back, posts the result and returns to idle to take the
// next request. A key of 0 and the unused op go straight to posting a result.
// A clear request sweeps the whole memory, one slot a cycle, then posts its
// result. After reset the same sweep runs with in_ready_o low; configuration
// writes are taken throughout.
// A finished result sits in an output register, so the next request is taken
// while it waits to be picked up.
module linear_probe_group_count
  import lpgc_pkg::*;
#(
  parameter int MAX_SLOTS = 1024
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  // request channel
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  input  wire logic [OpW-1:0]       op_i,
  input  wire logic [KeyW-1:0]      key_i,
  // result channel
  output logic                      out_valid_o,
  input  wire logic                 out_ready_i,
  output logic [CntW-1:0]           count_o,
  output logic [StatusW-1:0]        status_o,
  // configuration write port
  input  wire logic                 cfg_we_i,
  input  wire logic [CfgIdxW-1:0]   cfg_idx_i,
  input  wire logic [CfgDataW-1:0]  cfg_data_i
);

  localparam int AW = $clog2(MAX_SLOTS);
  localparam int NW = $clog2(MAX_SLOTS + 1);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_MUL,
    S_DIV,
    S_READ,
    S_CMP,
    S_RESP
  } state_e;

  state_e                 state_q;
  logic [OpW-1:0]         op_q;
  logic [KeyW-1:0]        key_q;
  logic [KeyW-1:0]        prod_q;
  logic [NW-1:0]          rem_q;
  logic [BitCntW-1:0]     bit_cnt_q;
  logic [AW-1:0]          addr_q;
  logic [NW-1:0]          probe_cnt_q;
  logic                   clr_item_q;
  logic [CntW-1:0]        res_count_q;
  logic [StatusW-1:0]     res_status_q;
  logic                   out_valid_q;
  logic [CntW-1:0]        count_q;
  logic [StatusW-1:0]     status_q;

  logic [CfgSizeW-1:0]    cfg_size_q;
  logic [KeyW-1:0]        cfg_mult_q;

  logic [KeyW+CntW-1:0]   slot_mem [MAX_SLOTS];
  logic [KeyW+CntW-1:0]   rd_data_q;

  logic [NW-1:0]          eff_n;
  logic [NW:0]            rem_shift;
  logic [NW:0]            rem_d;
  logic [KeyW-1:0]        rd_key;
  logic [CntW-1:0]        rd_count;
  logic                   hit;
  logic                   empty;
  logic                   last_probe;
  logic [AW-1:0]          addr_next;
  logic                   mem_we;
  logic [KeyW+CntW-1:0]   mem_wdata;
  logic                   res_post;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_size_q <= CFG_SIZE_RESET;
      cfg_mult_q <= CFG_MULT_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_TABLE_SIZE: cfg_size_q <= cfg_data_i[CfgSizeW-1:0];
        CFG_HASH_MULT:  cfg_mult_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // effective table size, clamped to 1..MAX_SLOTS
  always_comb begin
    if (cfg_size_q == '0) begin
      eff_n = NW'(1);
    end else if (32'(cfg_size_q) > 32'(MAX_SLOTS)) begin
      eff_n = NW'(MAX_SLOTS);
    end else begin
      eff_n = NW'(cfg_size_q);
    end
  end

  // one restoring remainder step per cycle
  always_comb begin
    rem_shift = {rem_q[NW-1:0], prod_q[KeyW-1]};
    if (rem_shift >= {1'b0, eff_n}) begin
      rem_d = rem_shift - {1'b0, eff_n};
    end else begin
      rem_d = rem_shift;
    end
  end

  // probe compare and wraparound
  assign rd_key     = rd_data_q[KeyW+CntW-1:CntW];
  assign rd_count   = rd_data_q[CntW-1:0];
  assign hit        = (rd_key == key_q);
  assign empty      = (rd_key == '0);
  assign last_probe = ((probe_cnt_q + NW'(1)) == eff_n);
  assign addr_next  = (((NW+1)'(addr_q) + (NW+1)'(1)) >= (NW+1)'(eff_n)) ? '0
                                                                          : addr_q + AW'(1);

  // result goes to the output register once it is free
  assign res_post = (state_q == S_RESP) && (!out_valid_q || out_ready_i);

  // slot memory write: clearing sweep or insert update
  always_comb begin
    mem_we    = 1'b0;
    mem_wdata = '0;
    case (state_q)
      S_CLEAR: begin
        mem_we = 1'b1;
      end
      S_CMP: begin
        if (op_q == OP_INSERT && (hit || empty)) begin
          mem_we = 1'b1;
          mem_wdata = {key_q, hit ? rd_count + CntW'(1) : CntW'(1)};
        end
      end
      default: ;
    endcase
  end

  // slot memory
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      slot_mem[addr_q] <= mem_wdata;
    end
    rd_data_q <= slot_mem[addr_q];
  end

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_CLEAR;
      op_q         <= '0;
      key_q        <= '0;
      prod_q       <= '0;
      rem_q        <= '0;
      bit_cnt_q    <= '0;
      addr_q       <= '0;
      probe_cnt_q  <= '0;
      clr_item_q   <= 1'b0;
      res_count_q  <= '0;
      res_status_q <= ST_OK;
      out_valid_q  <= 1'b0;
      count_q      <= '0;
      status_q     <= ST_OK;
    end else begin
      if (res_post) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        // sweep every slot to empty
        S_CLEAR: begin
          if (addr_q == AW'(MAX_SLOTS - 1)) begin
            addr_q       <= '0;
            res_count_q  <= '0;
            res_status_q <= ST_OK;
            state_q      <= clr_item_q ? S_RESP : S_IDLE;
          end else begin
            addr_q <= addr_q + AW'(1);
          end
        end
        // take a request
        S_IDLE: begin
          if (in_valid_i) begin
            op_q        <= op_i;
            key_q       <= key_i;
            res_count_q <= '0;
            if (op_i == OP_CLEAR) begin
              res_status_q <= ST_OK;
              clr_item_q   <= 1'b1;
              addr_q       <= '0;
              state_q      <= S_CLEAR;
            end else if (op_i inside {OP_INSERT, OP_QUERY}) begin
              if (key_i == '0) begin
                res_status_q <= ST_KEY0;
                state_q      <= S_RESP;
              end else begin
                res_status_q <= ST_OK;
                state_q      <= S_MUL;
              end
            end else begin
              res_status_q <= ST_OK;
              state_q      <= S_RESP;
            end
          end
        end
        // hash product, low word
        S_MUL: begin
          prod_q    <= key_q * cfg_mult_q;
          rem_q     <= '0;
          bit_cnt_q <= '0;
          state_q   <= S_DIV;
        end
        // home slot = product mod table size, one bit a cycle
        S_DIV: begin
          rem_q     <= rem_d[NW-1:0];
          prod_q    <= {prod_q[KeyW-2:0], 1'b0};
          bit_cnt_q <= bit_cnt_q + BitCntW'(1);
          if (bit_cnt_q == BitCntW'(KeyW - 1)) begin
            addr_q      <= rem_d[AW-1:0];
            probe_cnt_q <= '0;
            state_q     <= S_READ;
          end
        end
        // slot read in flight
        S_READ: begin
          state_q <= S_CMP;
        end
        // check the slot, update or step on
        S_CMP: begin
          if (hit || empty) begin
            state_q <= S_RESP;
            if (op_q == OP_QUERY) begin
              res_count_q  <= hit ? rd_count : '0;
              res_status_q <= hit ? ST_OK : ST_MISS;
            end else begin
              res_count_q  <= hit ? rd_count + CntW'(1) : CntW'(1);
              res_status_q <= ST_OK;
            end
          end else if (last_probe) begin
            state_q      <= S_RESP;
            res_count_q  <= '0;
            res_status_q <= (op_q == OP_INSERT) ? ST_FULL : ST_MISS;
          end else begin
            addr_q      <= addr_next;
            probe_cnt_q <= probe_cnt_q + NW'(1);
            state_q     <= S_READ;
          end
        end
        // post the result once the output register is free
        S_RESP: begin
          if (res_post) begin
            count_q    <= res_count_q;
            status_q   <= res_status_q;
            clr_item_q <= 1'b0;
            state_q    <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign count_o     = count_q;
  assign status_o    = status_q;

endmodule

`default_nettype wire

>>> src/lpgc_checker.sv
// port-level checks for the linear probing group-count table, with its bind
`timescale 1ns / 1ps
`default_nettype none

module lpgc_checker
  import lpgc_pkg::*;
(
  input wire logic                clk_i,
  input wire logic                rst_ni,
  input wire logic                in_valid_i,
  input wire logic                in_ready_o,
  input wire logic [OpW-1:0]      op_i,
  input wire logic [KeyW-1:0]     key_i,
  input wire logic                out_valid_o,
  input wire logic                out_ready_i,
  input wire logic [CntW-1:0]     count_o,
  input wire logic [StatusW-1:0]  status_o
);

  // a pending result holds until taken
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(count_o) && $stable(status_o))
    else $error("result changed while stalled");

  // one request at a time: no request taken right after another
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("request taken while busy");

  // a new result never appears while the block was idle
  a_result_after_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(!in_ready_o))
    else $error("result without work");

  // error results carry a zero count
  a_error_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == ST_MISS || status_o == ST_FULL || status_o == ST_KEY0)
      |-> count_o == '0)
    else $error("nonzero count on error status");

endmodule

bind linear_probe_group_count lpgc_checker u_lpgc_checker (.*);

`default_nettype wire
